[src/opt_pkg.sv]
package opt_pkg;

  localparam int CHANNELS      = 8;
  localparam int HISTORY_DEPTH = 64;
  localparam int COORD_BITS    = 16;

  // Field widths are fixed by the interface
  localparam int CHAN_W = 3;
  localparam int FLD_W  = 16;

  localparam int CRD_W    = (COORD_BITS < FLD_W) ? COORD_BITS : FLD_W;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HD_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LEN_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W    = CRD_W + $clog2(HISTORY_DEPTH);
  localparam int BOX_W    = 4 * CRD_W;
  localparam int DCNT_W   = $clog2(SUM_W + 1);
  localparam int RC_W     = 9;
  localparam int RC_MAX   = 511;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DLY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 2'd2;
  localparam int TD_W  = 9;
  localparam int RL_W  = 8;
  localparam int THR_W = 16;
  localparam logic [TD_W-1:0]  TD_RESET  = 9'd30;
  localparam logic [RL_W-1:0]  RL_RESET  = 8'd5;
  localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

  // Divide by five as multiply by 205 and shift by 10 (exact below 1024)
  localparam int RECIP5   = 205;
  localparam int RECIP5_W = 8;
  localparam int RECIP5_SH = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [FLD_W-1:0]  left;
    logic [FLD_W-1:0]  top;
    logic [FLD_W-1:0]  right;
    logic [FLD_W-1:0]  bottom;
  } in_data_t;

  typedef struct packed {
    logic alarm;
    logic accepted;
    logic cleared;
  } out_data_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic geo;
    logic mul1;
    logic uni;
    logic mul2;
    logic cmp;
    logic set_pass;
    logic rd_head;
    logic drop;
    logic push;
    logic rej;
    logic clear;
    logic alarm;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ch_bad;
    logic len_zero;
    logic pass;
    logic full;
    logic rc_over;
    logic need_alarm;
    logic out_busy;
  } status_t;

endpackage

[src/opt_div.sv]
module opt_div (
  input  logic                        clk,
  input  logic                        start,
  input  logic                        step,
  input  logic [opt_pkg::SUM_W-1:0]   dividend,
  input  logic [opt_pkg::LEN_W-1:0]   divisor,
  output logic [opt_pkg::CRD_W-1:0]   quotient
);

  logic [opt_pkg::SUM_W-1:0] quo_r, quo_nxt;
  logic [opt_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [opt_pkg::LEN_W:0]   trial;
  logic                      ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[opt_pkg::SUM_W-1]};
    ge    = trial >= {1'b0, divisor};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (step) begin
      quo_nxt = {quo_r[opt_pkg::SUM_W-2:0], ge};
      rem_nxt = ge ? opt_pkg::LEN_W'(trial - {1'b0, divisor})
                   : opt_pkg::LEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r[opt_pkg::CRD_W-1:0];

endmodule

[src/opt_ctrl.sv]
module opt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  opt_pkg::status_t st,
  output opt_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_GEO    = 4'd3;
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_UNI    = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_DROP1  = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;
  localparam logic [3:0] S_DEC    = 4'd11;
  localparam logic [3:0] S_DROP2  = 4'd12;
  localparam logic [3:0] S_COMMIT = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]                  state_r, state_nxt;
  logic [opt_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;

  // Sequence one item through check, divide, overlap, update and result
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.ch_bad) begin
          state_nxt = S_DONE;
        end else if (st.len_zero) begin
          cmd.set_pass = 1'b1;
          state_nxt    = S_UPD;
        end else begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == opt_pkg::DCNT_W'(opt_pkg::SUM_W - 1)) state_nxt = S_GEO;
      end
      S_GEO: begin
        cmd.geo   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_UNI;
      end
      S_UNI: begin
        cmd.uni   = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (st.pass) begin
          if (st.full) begin
            cmd.rd_head = 1'b1;
            state_nxt   = S_DROP1;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          cmd.rej   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DROP1: begin
        cmd.drop  = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (st.rc_over) begin
          cmd.clear = 1'b1;
          state_nxt = S_COMMIT;
        end else if (st.need_alarm) begin
          cmd.rd_head = 1'b1;
          cmd.alarm   = 1'b1;
          state_nxt   = S_DROP2;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DROP2: begin
        cmd.drop  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/opt_dp.sv]
module opt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  opt_pkg::in_data_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output opt_pkg::out_data_t                 out_data,
  input  logic                               cfg_we,
  input  logic [opt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [opt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  opt_pkg::cmd_t                      cmd,
  output opt_pkg::status_t                   st
);

  localparam int CW    = opt_pkg::CRD_W;
  localparam int A_W   = 2 * CW + 2;
  localparam int UNI_W = 2 * CW + 3;
  localparam int LO_W  = (UNI_W - 1) / 2;
  localparam int HI_W  = UNI_W - 1 - LO_W;
  localparam int P_W   = opt_pkg::THR_W + UNI_W - 1;
  localparam int MA_W  = opt_pkg::CH_IDX_W + opt_pkg::HD_W;
  localparam int MEM_D = 2 ** MA_W;
  localparam int TDP_W = opt_pkg::TD_W + opt_pkg::RECIP5_W;

  // Configuration
  logic [opt_pkg::TD_W-1:0]  td_r;
  logic [opt_pkg::RL_W-1:0]  rl_r;
  logic [opt_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r  <= opt_pkg::TD_RESET;
      rl_r  <= opt_pkg::RL_RESET;
      thr_r <= opt_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        opt_pkg::CFG_TRIG_DLY:      td_r  <= cfg_data[opt_pkg::TD_W-1:0];
        opt_pkg::CFG_REJECT_LIMIT:  rl_r  <= cfg_data[opt_pkg::RL_W-1:0];
        opt_pkg::CFG_IOU_THRESHOLD: thr_r <= cfg_data[opt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel state
  logic [opt_pkg::HD_W-1:0]  head_a [opt_pkg::CHANNELS];
  logic [opt_pkg::LEN_W-1:0] len_a  [opt_pkg::CHANNELS];
  logic [opt_pkg::SUM_W-1:0] sum_a  [opt_pkg::CHANNELS][4];
  logic [opt_pkg::RC_W-1:0]  rc_a   [opt_pkg::CHANNELS];

  // Item registers and working copy of the channel state
  logic [opt_pkg::CHAN_W-1:0] ch_r;
  logic [CW-1:0]              box_r [4];
  logic [opt_pkg::HD_W-1:0]   head_w;
  logic [opt_pkg::LEN_W-1:0]  len_w;
  logic [opt_pkg::SUM_W-1:0]  sum_w [4];
  logic [opt_pkg::RC_W-1:0]   rc_w;
  logic                       pass_r, alm_r, clr_r;
  logic                       out_valid_r;
  opt_pkg::out_data_t         out_r;

  logic [opt_pkg::CH_IDX_W-1:0] ch_idx, in_idx;
  assign ch_idx = opt_pkg::CH_IDX_W'(ch_r);
  assign in_idx = opt_pkg::CH_IDX_W'(in_data.channel);

  // History memory
  logic [opt_pkg::BOX_W-1:0] mem [MEM_D];
  logic [opt_pkg::BOX_W-1:0] rdata_r;
  logic                      mem_we;
  logic [MA_W-1:0]           mem_waddr;
  logic [opt_pkg::HD_W-1:0]  slot;
  logic [opt_pkg::HD_W:0]    slot_sum;
  logic [opt_pkg::BOX_W-1:0] box_word;

  assign box_word = {box_r[3], box_r[2], box_r[1], box_r[0]};
  assign slot_sum = {1'b0, head_w} + (opt_pkg::HD_W + 1)'(len_w);
  assign slot = (slot_sum >= (opt_pkg::HD_W + 1)'(opt_pkg::HISTORY_DEPTH))
              ? opt_pkg::HD_W'(slot_sum - (opt_pkg::HD_W + 1)'(opt_pkg::HISTORY_DEPTH))
              : opt_pkg::HD_W'(slot_sum);
  assign mem_we    = cmd.push || cmd.clear;
  assign mem_waddr = cmd.clear ? {ch_idx, {opt_pkg::HD_W{1'b0}}} : {ch_idx, slot};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= box_word;
    if (cmd.rd_head) rdata_r <= mem[{ch_idx, head_w}];
  end

  // Averaging dividers, one lane per coordinate
  logic [CW-1:0] avg [4];
  for (genvar i = 0; i < 4; i++) begin : g_div
    opt_div u_div (
      .clk      (clk),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_w[i]),
      .divisor  (len_w),
      .quotient (avg[i])
    );
  end

  // Overlap pipeline
  logic [CW-1:0]          w_r, h_r;
  logic signed [CW:0]     dxa_r, dya_r, dxb_r, dyb_r;
  logic [2*CW-1:0]        inter_r;
  logic signed [A_W-1:0]  a1_r, a2_r;
  logic [UNI_W-1:0]       uni_r;
  logic [opt_pkg::THR_W+LO_W-1:0] plo_r;
  logic [opt_pkg::THR_W+HI_W-1:0] phi_r;

  logic [CW-1:0]      mn_r, mx_l, mn_b, mx_t;
  logic signed [CW:0] w_s, h_s;
  logic [P_W-1:0]     prod, lhs;
  logic               cmp_pass;

  always_comb begin
    mn_r = (avg[2] < box_r[2]) ? avg[2] : box_r[2];
    mx_l = (avg[0] > box_r[0]) ? avg[0] : box_r[0];
    mn_b = (avg[3] < box_r[3]) ? avg[3] : box_r[3];
    mx_t = (avg[1] > box_r[1]) ? avg[1] : box_r[1];
    w_s  = $signed({1'b0, mn_r}) - $signed({1'b0, mx_l});
    h_s  = $signed({1'b0, mn_b}) - $signed({1'b0, mx_t});
    prod = (P_W'(phi_r) << LO_W) + P_W'(plo_r);
    lhs  = P_W'({inter_r, 16'd0});
    if (uni_r[UNI_W-1]) cmp_pass = 1'b0;
    else if (uni_r == '0) cmp_pass = inter_r != '0;
    else cmp_pass = lhs > prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.geo) begin
      w_r   <= w_s[CW] ? '0 : w_s[CW-1:0];
      h_r   <= h_s[CW] ? '0 : h_s[CW-1:0];
      dxa_r <= $signed({1'b0, avg[2]}) - $signed({1'b0, avg[0]});
      dya_r <= $signed({1'b0, avg[3]}) - $signed({1'b0, avg[1]});
      dxb_r <= $signed({1'b0, box_r[2]}) - $signed({1'b0, box_r[0]});
      dyb_r <= $signed({1'b0, box_r[3]}) - $signed({1'b0, box_r[1]});
    end
    if (cmd.mul1) begin
      inter_r <= w_r * h_r;
      a1_r    <= dya_r * dxa_r;
      a2_r    <= dyb_r * dxb_r;
    end
    if (cmd.uni) uni_r <= UNI_W'(a1_r) + UNI_W'(a2_r) - UNI_W'(inter_r);
    if (cmd.mul2) begin
      plo_r <= thr_r * uni_r[LO_W-1:0];
      phi_r <= thr_r * uni_r[UNI_W-2:LO_W];
    end
  end

  // Alarm length: delay register / 5
  logic [TDP_W-1:0]          td_prod;
  logic [opt_pkg::TD_W-1:0]  td5;
  assign td_prod = TDP_W'(td_r) * TDP_W'(opt_pkg::RECIP5);
  assign td5     = opt_pkg::TD_W'(td_prod >> opt_pkg::RECIP5_SH);

  // Status to the controller
  always_comb begin
    st.ch_bad     = int'(ch_r) >= opt_pkg::CHANNELS;
    st.len_zero   = len_w == '0;
    st.pass       = pass_r;
    st.full       = len_w == opt_pkg::LEN_W'(opt_pkg::HISTORY_DEPTH);
    st.rc_over    = rc_w > opt_pkg::RC_W'(rl_r);
    st.need_alarm = opt_pkg::TD_W'(len_w) > td5;
    st.out_busy   = out_valid_r && !out_ready;
  end

  logic [opt_pkg::HD_W-1:0] head_inc;
  assign head_inc = (head_w == opt_pkg::HD_W'(opt_pkg::HISTORY_DEPTH - 1))
                  ? '0 : head_w + 1'b1;

  // Working state: load, pass and alarm flags, drop, push, reject, clear
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_data.channel;
      box_r[0] <= in_data.left[CW-1:0];
      box_r[1] <= in_data.top[CW-1:0];
      box_r[2] <= in_data.right[CW-1:0];
      box_r[3] <= in_data.bottom[CW-1:0];
      head_w   <= head_a[in_idx];
      len_w    <= len_a[in_idx];
      rc_w     <= rc_a[in_idx];
      for (int i = 0; i < 4; i++) sum_w[i] <= sum_a[in_idx][i];
      pass_r   <= 1'b0;
      alm_r    <= 1'b0;
      clr_r    <= 1'b0;
    end
    if (cmd.set_pass || cmd.cmp) pass_r <= cmd.set_pass || cmp_pass;
    if (cmd.alarm) alm_r <= 1'b1;
    if (cmd.drop) begin
      for (int i = 0; i < 4; i++)
        sum_w[i] <= sum_w[i] - opt_pkg::SUM_W'(rdata_r[i*CW +: CW]);
      head_w <= head_inc;
      len_w  <= len_w - 1'b1;
    end
    if (cmd.push) begin
      for (int i = 0; i < 4; i++) sum_w[i] <= sum_w[i] + opt_pkg::SUM_W'(box_r[i]);
      len_w <= len_w + 1'b1;
    end
    if (cmd.rej && rc_w != opt_pkg::RC_W'(opt_pkg::RC_MAX)) rc_w <= rc_w + 1'b1;
    if (cmd.clear) begin
      for (int i = 0; i < 4; i++) sum_w[i] <= opt_pkg::SUM_W'(box_r[i]);
      head_w <= '0;
      len_w  <= opt_pkg::LEN_W'(1);
      rc_w   <= '0;
      clr_r  <= 1'b1;
    end
  end

  // Write the working copy back to the channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < opt_pkg::CHANNELS; c++) begin
        head_a[c] <= '0;
        len_a[c]  <= '0;
        rc_a[c]   <= '0;
        for (int i = 0; i < 4; i++) sum_a[c][i] <= '0;
      end
    end else if (cmd.commit) begin
      head_a[ch_idx] <= head_w;
      len_a[ch_idx]  <= len_w;
      rc_a[ch_idx]   <= rc_w;
      for (int i = 0; i < 4; i++) sum_a[ch_idx][i] <= sum_w[i];
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.alarm    <= alm_r && !st.ch_bad;
      out_r.accepted <= pass_r && !st.ch_bad;
      out_r.cleared  <= clr_r && !st.ch_bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/overlap_persistence_trigger.sv]
// Flow: for a channel with history, a 22-step divide of the four coordinate sums,
//   then overlap multiply and compare; an empty channel history skips both.
// Throughput: one item at a time; a held result stalls the next item.
// Reset: rst_n synchronous, active low; clears all channel state and loads register
//   defaults. The history memory is not cleared: only written entries are ever read.
module overlap_persistence_trigger (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  opt_pkg::in_data_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output opt_pkg::out_data_t              out_data,
  input  logic                            cfg_we,
  input  logic [opt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [opt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  opt_pkg::cmd_t    cmd;
  opt_pkg::status_t st;

  opt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  opt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

  // A clear seeds the history and never raises the alarm
  a_clr_no_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.cleared && out_data.alarm))
    else $error("cleared and alarm together");

  // One item at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // A result appears only after the item has been worked on
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

[test/tb_overlap_persistence_trigger.sv]
`timescale 1ns / 100ps

module tb_overlap_persistence_trigger;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int EXP_DEPTH = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  opt_pkg::in_data_t in_data;
  logic out_valid;
  logic out_ready;
  opt_pkg::out_data_t out_data;
  logic cfg_we;
  logic [opt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [opt_pkg::CFG_DATA_W-1:0] cfg_data;

  overlap_persistence_trigger u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state, one ring per channel
  logic [15:0] ring_box [opt_pkg::CHANNELS][opt_pkg::HISTORY_DEPTH][4];
  int unsigned ring_head [opt_pkg::CHANNELS];
  int unsigned ring_len [opt_pkg::CHANNELS];
  longint unsigned ring_sum [opt_pkg::CHANNELS][4];
  int unsigned rej_cnt [opt_pkg::CHANNELS];
  int unsigned trig_delay;
  int unsigned rej_limit;
  int unsigned iou_thr;

  // Expected results in order of input transfer
  opt_pkg::out_data_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int err_count;
  longint unsigned cycle_count;

  bit idle_enable;   // random idling on/off
  bit hold_rx;       // long receiver hold-off request

  // Base boxes for well-formed tracks per channel
  logic [15:0] track_box [opt_pkg::CHANNELS][4];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_overlap_persistence_trigger: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void drop_oldest_box(input int c);
    int unsigned h;
    h = ring_head[c] % opt_pkg::HISTORY_DEPTH;
    for (int k = 0; k < 4; k++) ring_sum[c][k] -= ring_box[c][h][k];
    ring_head[c] = (h + 1) % opt_pkg::HISTORY_DEPTH;
    ring_len[c]--;
  endfunction

  function automatic void push_new_box(input int c, input logic [15:0] b [4]);
    int unsigned slot;
    if (ring_len[c] >= opt_pkg::HISTORY_DEPTH) drop_oldest_box(c);
    slot = (ring_head[c] + ring_len[c]) % opt_pkg::HISTORY_DEPTH;
    for (int k = 0; k < 4; k++) begin
      ring_box[c][slot][k] = b[k];
      ring_sum[c][k] += b[k];
    end
    ring_len[c]++;
  endfunction

  function automatic bit overlap_ok(input int c, input logic [15:0] b [4]);
    longint avg [4];
    longint bx [4];
    longint w, h, inter, uni;
    logic [127:0] lhs, rhs;
    for (int k = 0; k < 4; k++) begin
      avg[k] = longint'(ring_sum[c][k] / ring_len[c]);
      bx[k] = longint'(b[k]);
    end
    w = ((avg[2] < bx[2]) ? avg[2] : bx[2]) - ((avg[0] > bx[0]) ? avg[0] : bx[0]);
    h = ((avg[3] < bx[3]) ? avg[3] : bx[3]) - ((avg[1] > bx[1]) ? avg[1] : bx[1]);
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    uni = (avg[3] - avg[1]) * (avg[2] - avg[0]) + (bx[3] - bx[1]) * (bx[2] - bx[0]) - inter;
    if (uni <= 0) return (uni == 0) && (inter > 0);
    lhs = 128'(inter) << 16;
    rhs = 128'(iou_thr) * 128'(uni);
    return lhs > rhs;
  endfunction

  function automatic opt_pkg::out_data_t predict_verdict(input opt_pkg::in_data_t it);
    opt_pkg::out_data_t r;
    int c;
    logic [15:0] b [4];
    r = '0;
    c = it.channel;
    if (c >= opt_pkg::CHANNELS) return r;
    b[0] = it.left; b[1] = it.top; b[2] = it.right; b[3] = it.bottom;
    if (ring_len[c] == 0 || overlap_ok(c, b)) begin
      r.accepted = 1'b1;
      push_new_box(c, b);
    end else if (rej_cnt[c] < opt_pkg::RC_MAX) begin
      rej_cnt[c]++;
    end
    if (rej_cnt[c] > rej_limit) begin
      ring_head[c] = 0;
      ring_len[c] = 0;
      for (int k = 0; k < 4; k++) ring_sum[c][k] = 0;
      rej_cnt[c] = 0;
      push_new_box(c, b);
      r.cleared = 1'b1;
    end else if (ring_len[c] > trig_delay / 5) begin
      r.alarm = 1'b1;
      drop_oldest_box(c);
    end
    return r;
  endfunction

  // Send one box; predict at the transfer edge, hold valid until the next falling edge
  task automatic send_box(input opt_pkg::in_data_t it);
    if (idle_enable) begin
      while ($urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_mem[exp_wr % EXP_DEPTH] = predict_verdict(it);
    exp_wr++;
    @(negedge clk);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    opt_pkg::out_data_t exp_v;
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_v = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.alarm !== exp_v.alarm)
          report_mismatch($sformatf("alarm %b exp %b", out_data.alarm, exp_v.alarm));
        if (out_data.accepted !== exp_v.accepted)
          report_mismatch($sformatf("accepted %b exp %b", out_data.accepted, exp_v.accepted));
        if (out_data.cleared !== exp_v.cleared)
          report_mismatch($sformatf("cleared %b exp %b", out_data.cleared, exp_v.cleared));
      end
    end
  end

  // Drive receiver readiness
  always @(negedge clk) begin
    if (hold_rx) out_ready <= 1'b0;
    else if (idle_enable) out_ready <= ($urandom_range(99) >= 38);
    else out_ready <= 1'b1;
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [opt_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[opt_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == opt_pkg::CFG_TRIG_DLY) trig_delay = val & 'h1FF;
    else if (idx == opt_pkg::CFG_REJECT_LIMIT) rej_limit = val & 'hFF;
    else if (idx == opt_pkg::CFG_IOU_THRESHOLD) iou_thr = val & 'hFFFF;
    @(negedge clk);
  endtask

  function automatic opt_pkg::in_data_t make_box(input int ch, input int l, input int t,
                                                 input int r, input int b);
    opt_pkg::in_data_t it;
    it.channel = ch[2:0];
    it.left = l[15:0];
    it.top = t[15:0];
    it.right = r[15:0];
    it.bottom = b[15:0];
    return it;
  endfunction

  // Box near the channel's track, jittered a little
  function automatic opt_pkg::in_data_t track_item(input int ch);
    opt_pkg::in_data_t it;
    int j [4];
    for (int k = 0; k < 4; k++)
      j[k] = int'(track_box[ch][k]) + int'($urandom_range(6)) - 3;
    for (int k = 0; k < 4; k++) if (j[k] < 0) j[k] = 0; else if (j[k] > 65535) j[k] = 65535;
    it = make_box(ch, j[0], j[1], j[2], j[3]);
    return it;
  endfunction

  function automatic void new_track(input int ch);
    int l, t;
    l = $urandom_range(60000);
    t = $urandom_range(60000);
    track_box[ch][0] = 16'(l);
    track_box[ch][1] = 16'(t);
    track_box[ch][2] = 16'(l + 20 + int'($urandom_range(5000)));
    track_box[ch][3] = 16'(t + 20 + int'($urandom_range(5000)));
  endfunction

  function automatic opt_pkg::in_data_t noise_item();
    opt_pkg::in_data_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(opt_pkg::in_data_t)-1:0];
    return it;
  endfunction

  task automatic test_directed_edges();
    // empty ring accept, then identical box, zero-area, inverted and extremes
    send_box(make_box(0, 100, 100, 200, 200));
    send_box(make_box(0, 100, 100, 200, 200));
    send_box(make_box(0, 5000, 5000, 6000, 6000));
    send_box(make_box(1, 0, 0, 0, 0));
    send_box(make_box(1, 0, 0, 0, 0));
    send_box(make_box(2, 65535, 65535, 0, 0));
    send_box(make_box(2, 0, 0, 65535, 65535));
    send_box(make_box(3, 0, 0, 65535, 65535));
    send_box(make_box(3, 0, 0, 65535, 65535));
    send_box(make_box(4, 10, 10, 20, 20));
    // inverted second box: positive signed area, zero intersection
    send_box(make_box(4, 20, 20, 10, 10));
    send_box(make_box(7, 65535, 0, 65535, 0));
    send_box(make_box(7, 1, 1, 2, 2));
    // reject until clear
    for (int i = 0; i < 7; i++) send_box(make_box(5, 1000 * i, 0, 1000 * i + 10, 10));
    wait_drained();
  endtask

  task automatic test_config_sweep();
    int unsigned td_set [4] = '{0, 315, 4, 511};
    int unsigned rl_set [4] = '{0, 255, 1, 3};
    int unsigned th_set [4] = '{0, 65535, 1, 40000};
    for (int s = 0; s < 4; s++) begin
      write_reg(opt_pkg::CFG_TRIG_DLY, td_set[s]);
      write_reg(opt_pkg::CFG_REJECT_LIMIT, rl_set[s]);
      write_reg(opt_pkg::CFG_IOU_THRESHOLD, th_set[s]);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(9) < 8) send_box(track_item($urandom_range(7)));
        else send_box(noise_item());
      end
      wait_drained();
    end
    // lower the limit below existing reject counts
    write_reg(opt_pkg::CFG_REJECT_LIMIT, 0);
    for (int c = 0; c < opt_pkg::CHANNELS; c++) send_box(track_item(c));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_box(track_item($urandom_range(7)));
    join
    wait_drained();
  endtask

  task automatic test_random_tracks(input int count, input bit idles);
    int ch;
    idle_enable = idles;
    for (int i = 0; i < count; i++) begin
      ch = $urandom_range(7);
      if ($urandom_range(49) == 0) new_track(ch);
      if ($urandom_range(99) < 80) send_box(track_item(ch));
      else send_box(noise_item());
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    cycle_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    idle_enable = 1'b1;
    hold_rx = 1'b0;
    trig_delay = opt_pkg::TD_RESET;
    rej_limit = opt_pkg::RL_RESET;
    iou_thr = opt_pkg::THR_RESET;
    for (int c = 0; c < opt_pkg::CHANNELS; c++) begin
      ring_head[c] = 0;
      ring_len[c] = 0;
      rej_cnt[c] = 0;
      for (int k = 0; k < 4; k++) ring_sum[c][k] = 0;
      new_track(c);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_config_sweep();
    write_reg(opt_pkg::CFG_TRIG_DLY, 30);
    write_reg(opt_pkg::CFG_REJECT_LIMIT, 5);
    write_reg(opt_pkg::CFG_IOU_THRESHOLD, 32768);
    test_backpressure();
    test_random_tracks(100, 1'b0);
    test_random_tracks(160, 1'b1);

    if (err_count == 0) begin
      $display("tb_overlap_persistence_trigger: done, clean");
    end else begin
      $display("tb_overlap_persistence_trigger: done, errors");
    end
    $finish;
  end

endmodule
